// File: rtl/assert_macros.svh
// Assertion macros for the block sender RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_IMPLIES(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define ASSERT_IMPLIES(label, clk, rst, cond, expr, msg)
`endif
`endif

// File: rtl/ybs_pkg.sv
// Types, constants and the CRC helper of the YMODEM block sender.
`default_nettype none
package ybs_pkg;

  localparam int BLOCK_BYTES = 1024;
  localparam int SHORT_BYTES = 128;
  localparam int ADDR_W      = $clog2(BLOCK_BYTES);
  localparam int CNT_W       = 11;

  localparam logic [7:0] CH_C   = 8'h43;
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CH_PAD = 8'h1A;

  localparam logic [1:0] REG_RETRY_LIMIT     = 2'd0;
  localparam logic [1:0] REG_HANDSHAKE_TRIES = 2'd1;
  localparam logic [1:0] REG_ORIGINAL_MODE   = 2'd2;

  typedef enum logic [2:0] {
    OP_START   = 3'd0,
    OP_PAYLOAD = 3'd1,
    OP_RX      = 3'd2,
    OP_PULL    = 3'd3,
    OP_TIMEOUT = 3'd4,
    OP_EOF     = 3'd5
  } opcode_t;

  typedef enum logic [2:0] {
    ST_READY     = 3'd0,
    ST_ACCEPTED  = 3'd1,
    ST_COMPLETE  = 3'd2,
    ST_NO_RESP   = 3'd3,
    ST_CANCELLED = 3'd4,
    ST_RETRIES   = 3'd5,
    ST_HS_FAIL   = 3'd6,
    ST_OVERLONG  = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE, PH_HANDSHAKE, PH_FILL, PH_SEND, PH_WAIT_ACK, PH_WAIT_C, PH_CLOSE_TX, PH_CLOSE_RX
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA, KIND_NAME, KIND_NULL
  } kind_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] data_byte;
    logic       last_in_block;
  } in_beat_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] tx_byte;
    logic       last_of_packet;
    logic [2:0] status;
  } out_beat_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ 16'h1021;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/ymodem_block_sender.sv
// Top level of the YMODEM block sender: session control, block buffer and frame output.
//
//   channel   direction  handshake           payload
//   in        in         in_valid/in_stall   in_data (ybs_pkg::in_beat_t)
//   out       out        out_valid/out_stall out_data (ybs_pkg::out_beat_t)
//   cfg       in         cfg_we              cfg_index, cfg_data
//
// One beat is taken every cycle while in_stall is low; its result sits in the output register in the next cycle.
// The block buffer read is registered and always tracks the next frame position.
// in_stall is high only while a result waits in the output register under out_stall.
// Reset is synchronous; no clearing pass is needed for the buffer.
`default_nettype none
`include "assert_macros.svh"
module ymodem_block_sender (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire ybs_pkg::in_beat_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output ybs_pkg::out_beat_t    out_data,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [7:0]       cfg_data
);

  localparam int CW = ybs_pkg::CNT_W;
  localparam int AW = ybs_pkg::ADDR_W;
  localparam logic [CW-1:0] LONG_LEN  = CW'(ybs_pkg::BLOCK_BYTES);
  localparam logic [CW-1:0] SHORT_LEN = CW'(ybs_pkg::SHORT_BYTES);

  logic [7:0] retry_limit, handshake_tries;
  logic       original_mode;

  logic [7:0] packet_store [ybs_pkg::BLOCK_BYTES];
  logic [7:0] store_q;

  ybs_pkg::phase_t phase, phase_next;
  ybs_pkg::kind_t  packet_kind, packet_kind_next;
  logic [CW-1:0] fill_count, fill_count_next;
  logic [CW-1:0] send_pointer, send_pointer_next;
  logic [7:0]    block_number, block_number_next;
  logic          long_block, long_block_next;
  logic [15:0]   crc_accum, crc_accum_next;
  logic [7:0]    attempts_left, attempts_left_next;
  logic [7:0]    handshake_left, handshake_left_next;
  logic [1:0]    closing_step, closing_step_next;

  logic      accept;
  logic      res_valid;
  ybs_pkg::out_beat_t res;
  logic [2:0] op;
  logic [7:0] b;

  // Frame byte generation for a pull.
  logic [CW-1:0] frame_len, pay_idx;
  logic [7:0]    pay_byte, pull_byte;
  logic          pull_last, pull_in_payload, overflow, write_en;
  logic [AW-1:0] rd_addr;

  assign accept   = in_valid && !in_stall;
  assign in_stall = out_valid && out_stall;
  assign op       = in_data.opcode;
  assign b        = in_data.data_byte;

  assign frame_len = long_block ? LONG_LEN : SHORT_LEN;
  assign pay_idx   = send_pointer - CW'(3);
  assign pay_byte  = (pay_idx < fill_count) ? store_q :
                     ((packet_kind == ybs_pkg::KIND_DATA) ? ybs_pkg::CH_PAD : 8'h00);
  assign overflow  = fill_count >= ((packet_kind == ybs_pkg::KIND_NAME) ? SHORT_LEN : LONG_LEN);
  assign rd_addr   = AW'(send_pointer_next - CW'(3));
  assign write_en  = accept && (op != ybs_pkg::OP_START) && (phase == ybs_pkg::PH_FILL) &&
                     (op == ybs_pkg::OP_PAYLOAD) && !overflow;

  always_comb begin
    pull_in_payload = 1'b0;
    pull_last       = 1'b0;
    if (send_pointer == CW'(0)) begin
      pull_byte = long_block ? ybs_pkg::CH_STX : ybs_pkg::CH_SOH;
    end else if (send_pointer == CW'(1)) begin
      pull_byte = block_number;
    end else if (send_pointer == CW'(2)) begin
      pull_byte = ~block_number;
    end else if (send_pointer < frame_len + CW'(3)) begin
      pull_byte       = pay_byte;
      pull_in_payload = 1'b1;
    end else if (send_pointer == frame_len + CW'(3)) begin
      pull_byte = crc_accum[15:8];
    end else begin
      pull_byte = crc_accum[7:0];
      pull_last = 1'b1;
    end
  end

  // Next-state logic.
  always_comb begin
    phase_next          = phase;
    packet_kind_next    = packet_kind;
    fill_count_next     = fill_count;
    send_pointer_next   = send_pointer;
    block_number_next   = block_number;
    long_block_next     = long_block;
    crc_accum_next      = crc_accum;
    attempts_left_next  = attempts_left;
    handshake_left_next = handshake_left;
    closing_step_next   = closing_step;
    if (accept) begin
      if (op == ybs_pkg::OP_START) begin
        handshake_left_next = (handshake_tries != 8'd0) ? handshake_tries : 8'd1;
        block_number_next   = 8'd0;
        closing_step_next   = 2'd0;
        phase_next          = ybs_pkg::PH_HANDSHAKE;
      end else begin
        case (phase)
          ybs_pkg::PH_HANDSHAKE: begin
            if (op == ybs_pkg::OP_RX && b == ybs_pkg::CH_C) begin
              block_number_next = 8'd0;
              packet_kind_next  = ybs_pkg::KIND_NAME;
              fill_count_next   = '0;
              phase_next        = ybs_pkg::PH_FILL;
            end else if (op == ybs_pkg::OP_RX || op == ybs_pkg::OP_TIMEOUT) begin
              if (handshake_left > 8'd1) begin
                handshake_left_next = handshake_left - 8'd1;
              end else begin
                phase_next = ybs_pkg::PH_IDLE;
              end
            end
          end
          ybs_pkg::PH_FILL: begin
            if (op == ybs_pkg::OP_PAYLOAD) begin
              if (overflow) begin
                phase_next = ybs_pkg::PH_IDLE;
              end else begin
                fill_count_next = fill_count + CW'(1);
                if (in_data.last_in_block) begin
                  long_block_next = (packet_kind == ybs_pkg::KIND_DATA) &&
                                    (fill_count + CW'(1) > SHORT_LEN);
                  if (packet_kind == ybs_pkg::KIND_DATA && !original_mode) begin
                    attempts_left_next = (retry_limit != 8'd0) ? retry_limit : 8'd1;
                  end else begin
                    attempts_left_next = 8'd1;
                  end
                  send_pointer_next = '0;
                  crc_accum_next    = 16'h0000;
                  phase_next        = ybs_pkg::PH_SEND;
                end
              end
            end else if (op == ybs_pkg::OP_EOF && packet_kind == ybs_pkg::KIND_DATA &&
                         fill_count == '0) begin
              closing_step_next = 2'd0;
              phase_next        = ybs_pkg::PH_CLOSE_TX;
            end
          end
          ybs_pkg::PH_SEND: begin
            if (op == ybs_pkg::OP_PULL) begin
              send_pointer_next = send_pointer + CW'(1);
              if (pull_in_payload) begin
                crc_accum_next = ybs_pkg::crc_byte(crc_accum, pull_byte);
              end
              if (pull_last) begin
                phase_next = ybs_pkg::PH_WAIT_ACK;
              end
            end
          end
          ybs_pkg::PH_WAIT_ACK: begin
            if (op == ybs_pkg::OP_RX) begin
              if (b == ybs_pkg::CH_ACK) begin
                if (packet_kind == ybs_pkg::KIND_NAME) begin
                  phase_next = ybs_pkg::PH_WAIT_C;
                end else if (packet_kind == ybs_pkg::KIND_NULL) begin
                  phase_next = ybs_pkg::PH_IDLE;
                end else begin
                  block_number_next = block_number + 8'd1;
                  packet_kind_next  = ybs_pkg::KIND_DATA;
                  fill_count_next   = '0;
                  phase_next        = ybs_pkg::PH_FILL;
                end
              end else if (b == ybs_pkg::CH_CAN && !original_mode) begin
                phase_next = ybs_pkg::PH_IDLE;
              end else if (attempts_left > 8'd1) begin
                attempts_left_next = attempts_left - 8'd1;
                send_pointer_next  = '0;
                crc_accum_next     = 16'h0000;
                phase_next         = ybs_pkg::PH_SEND;
              end else begin
                phase_next = ybs_pkg::PH_IDLE;
              end
            end else if (op == ybs_pkg::OP_TIMEOUT) begin
              phase_next = ybs_pkg::PH_IDLE;
            end
          end
          ybs_pkg::PH_WAIT_C: begin
            if (op == ybs_pkg::OP_RX) begin
              if (b != ybs_pkg::CH_C) begin
                phase_next = ybs_pkg::PH_IDLE;
              end else begin
                block_number_next = 8'd1;
                packet_kind_next  = ybs_pkg::KIND_DATA;
                fill_count_next   = '0;
                phase_next        = ybs_pkg::PH_FILL;
              end
            end else if (op == ybs_pkg::OP_TIMEOUT) begin
              phase_next = ybs_pkg::PH_IDLE;
            end
          end
          ybs_pkg::PH_CLOSE_TX: begin
            if (op == ybs_pkg::OP_PULL) begin
              phase_next = ybs_pkg::PH_CLOSE_RX;
            end
          end
          ybs_pkg::PH_CLOSE_RX: begin
            if (op == ybs_pkg::OP_RX) begin
              if (closing_step == 2'd0) begin
                if (!original_mode || b != ybs_pkg::CH_NAK) begin
                  phase_next = ybs_pkg::PH_IDLE;
                end else begin
                  closing_step_next = 2'd1;
                  phase_next        = ybs_pkg::PH_CLOSE_TX;
                end
              end else if (closing_step == 2'd1) begin
                if (b != ybs_pkg::CH_ACK) begin
                  phase_next = ybs_pkg::PH_IDLE;
                end else begin
                  closing_step_next = 2'd2;
                end
              end else if (b != ybs_pkg::CH_C) begin
                phase_next = ybs_pkg::PH_IDLE;
              end else begin
                // 'C' after the close: send the empty block 0.
                packet_kind_next   = ybs_pkg::KIND_NULL;
                fill_count_next    = '0;
                long_block_next    = 1'b0;
                block_number_next  = 8'd0;
                attempts_left_next = 8'd1;
                send_pointer_next  = '0;
                crc_accum_next     = 16'h0000;
                phase_next         = ybs_pkg::PH_SEND;
              end
            end else if (op == ybs_pkg::OP_TIMEOUT) begin
              phase_next = ybs_pkg::PH_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Result logic.
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    res.result_kind = 1'b1;
    if (accept && op != ybs_pkg::OP_START) begin
      case (phase)
        ybs_pkg::PH_HANDSHAKE: begin
          if (op == ybs_pkg::OP_RX && b == ybs_pkg::CH_C) begin
            res_valid  = 1'b1;
            res.status = ybs_pkg::ST_READY;
          end else if ((op == ybs_pkg::OP_RX || op == ybs_pkg::OP_TIMEOUT) &&
                       handshake_left <= 8'd1) begin
            res_valid  = 1'b1;
            res.status = ybs_pkg::ST_HS_FAIL;
          end
        end
        ybs_pkg::PH_FILL: begin
          if (op == ybs_pkg::OP_PAYLOAD && overflow) begin
            res_valid  = 1'b1;
            res.status = ybs_pkg::ST_OVERLONG;
          end
        end
        ybs_pkg::PH_SEND: begin
          if (op == ybs_pkg::OP_PULL) begin
            res_valid          = 1'b1;
            res.result_kind    = 1'b0;
            res.tx_byte        = pull_byte;
            res.last_of_packet = pull_last;
          end
        end
        ybs_pkg::PH_WAIT_ACK: begin
          if (op == ybs_pkg::OP_RX) begin
            if (b == ybs_pkg::CH_ACK) begin
              if (packet_kind == ybs_pkg::KIND_NULL) begin
                res_valid  = 1'b1;
                res.status = ybs_pkg::ST_COMPLETE;
              end else if (packet_kind == ybs_pkg::KIND_DATA) begin
                res_valid  = 1'b1;
                res.status = ybs_pkg::ST_ACCEPTED;
              end
            end else if (b == ybs_pkg::CH_CAN && !original_mode) begin
              res_valid  = 1'b1;
              res.status = ybs_pkg::ST_CANCELLED;
            end else if (attempts_left <= 8'd1) begin
              res_valid  = 1'b1;
              res.status = ybs_pkg::ST_RETRIES;
            end
          end else if (op == ybs_pkg::OP_TIMEOUT) begin
            res_valid  = 1'b1;
            res.status = ybs_pkg::ST_NO_RESP;
          end
        end
        ybs_pkg::PH_WAIT_C: begin
          if (op == ybs_pkg::OP_RX) begin
            res_valid  = 1'b1;
            res.status = (b != ybs_pkg::CH_C) ? ybs_pkg::ST_HS_FAIL : ybs_pkg::ST_READY;
          end else if (op == ybs_pkg::OP_TIMEOUT) begin
            res_valid  = 1'b1;
            res.status = ybs_pkg::ST_NO_RESP;
          end
        end
        ybs_pkg::PH_CLOSE_TX: begin
          if (op == ybs_pkg::OP_PULL) begin
            res_valid          = 1'b1;
            res.result_kind    = 1'b0;
            res.tx_byte        = ybs_pkg::CH_EOT;
            res.last_of_packet = 1'b1;
          end
        end
        ybs_pkg::PH_CLOSE_RX: begin
          if (op == ybs_pkg::OP_RX) begin
            if (closing_step == 2'd0) begin
              if (!original_mode) begin
                res_valid  = 1'b1;
                res.status = (b == ybs_pkg::CH_ACK) ? ybs_pkg::ST_COMPLETE : ybs_pkg::ST_RETRIES;
              end else if (b != ybs_pkg::CH_NAK) begin
                res_valid  = 1'b1;
                res.status = ybs_pkg::ST_RETRIES;
              end
            end else if (closing_step == 2'd1) begin
              if (b != ybs_pkg::CH_ACK) begin
                res_valid  = 1'b1;
                res.status = ybs_pkg::ST_RETRIES;
              end
            end else if (b != ybs_pkg::CH_C) begin
              res_valid  = 1'b1;
              res.status = ybs_pkg::ST_RETRIES;
            end
          end else if (op == ybs_pkg::OP_TIMEOUT) begin
            res_valid  = 1'b1;
            res.status = ybs_pkg::ST_NO_RESP;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Block buffer: one write port, one registered read that follows the frame position.
  always_ff @(posedge clk) begin
    if (write_en) begin
      packet_store[AW'(fill_count)] <= b;
    end
    store_q <= packet_store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit     <= 8'd10;
      handshake_tries <= 8'd10;
      original_mode   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        ybs_pkg::REG_RETRY_LIMIT:     retry_limit     <= cfg_data;
        ybs_pkg::REG_HANDSHAKE_TRIES: handshake_tries <= cfg_data;
        ybs_pkg::REG_ORIGINAL_MODE:   original_mode   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= ybs_pkg::PH_IDLE;
      packet_kind    <= ybs_pkg::KIND_DATA;
      fill_count     <= '0;
      send_pointer   <= '0;
      block_number   <= 8'd0;
      long_block     <= 1'b0;
      crc_accum      <= 16'h0000;
      attempts_left  <= 8'd0;
      handshake_left <= 8'd0;
      closing_step   <= 2'd0;
      out_valid      <= 1'b0;
    end else begin
      phase          <= phase_next;
      packet_kind    <= packet_kind_next;
      fill_count     <= fill_count_next;
      send_pointer   <= send_pointer_next;
      block_number   <= block_number_next;
      long_block     <= long_block_next;
      crc_accum      <= crc_accum_next;
      attempts_left  <= attempts_left_next;
      handshake_left <= handshake_left_next;
      closing_step   <= closing_step_next;
      if (accept) begin
        out_valid <= res_valid;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= res;
    end
  end

  `ASSERT_ALWAYS(a_fill_bound, clk, rst, fill_count <= LONG_LEN, "fill count past block size")
  `ASSERT_IMPLIES(a_ptr_bound, clk, rst, phase == ybs_pkg::PH_SEND, send_pointer <= LONG_LEN + CW'(4), "send pointer past frame")
  `ASSERT_IMPLIES(a_close_step, clk, rst, phase == ybs_pkg::PH_CLOSE_RX, closing_step <= 2'd2, "bad closing step")
  `ASSERT_IMPLIES(a_tx_status, clk, rst, out_valid && !out_data.result_kind, out_data.status == 3'd0, "transmit beat carries status")

endmodule
`default_nettype wire

// File: tb/ybs_checker.sv
// Checker for the YMODEM block sender: predicts every output beat and compares it on arrival.
module ybs_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  ybs_pkg::in_beat_t   in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  ybs_pkg::out_beat_t  out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  output int                  errors,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]  retries_cfg, tries_cfg;
  logic        strict_cfg;

  logic [7:0]  frame_buf [ybs_pkg::BLOCK_BYTES];
  logic [10:0] filled, tx_pos;
  logic [7:0]  blk_num, tries_left, hs_left;
  logic        is_long;
  logic [15:0] crc_run;
  logic [2:0]  close_step;
  ybs_pkg::phase_t ph;
  ybs_pkg::kind_t  kind;

  ybs_pkg::out_beat_t expected_beats[$];

  assign pending = expected_beats.size();

  function automatic logic [15:0] crc16_next(logic [15:0] acc, logic [7:0] b);
    logic [15:0] r;
    r = acc;
    for (int k = 7; k >= 0; k--) begin
      if (r[15] ^ b[k]) begin
        r = (r << 1) ^ 16'h1021;
      end else begin
        r = r << 1;
      end
    end
    return r;
  endfunction

  task automatic queue_tx(logic [7:0] b, logic last);
    expected_beats.push_back(ybs_pkg::out_beat_t'{1'b0, b, last, 3'd0});
  endtask

  task automatic queue_status(ybs_pkg::status_t s);
    expected_beats.push_back(ybs_pkg::out_beat_t'{1'b1, 8'h00, 1'b0, s});
  endtask

  task automatic abort_with(ybs_pkg::status_t s);
    ph = ybs_pkg::PH_IDLE;
    queue_status(s);
  endtask

  task automatic start_frame();
    tx_pos  = '0;
    crc_run = '0;
    ph      = ybs_pkg::PH_SEND;
  endtask

  task automatic start_fill(ybs_pkg::kind_t k);
    kind   = k;
    filled = '0;
    ph     = ybs_pkg::PH_FILL;
  endtask

  task automatic next_frame_byte();
    logic [10:0] len, p;
    logic [7:0]  b;
    logic        last;
    len  = is_long ? 11'(ybs_pkg::BLOCK_BYTES) : 11'(ybs_pkg::SHORT_BYTES);
    p    = tx_pos;
    last = 1'b0;
    if (p == 0) begin
      b = is_long ? ybs_pkg::CH_STX : ybs_pkg::CH_SOH;
    end else if (p == 1) begin
      b = blk_num;
    end else if (p == 2) begin
      b = ~blk_num;
    end else if (p < len + 3) begin
      if (p - 3 < filled) begin
        b = frame_buf[10'(p - 3)];
      end else begin
        b = (kind == ybs_pkg::KIND_DATA) ? ybs_pkg::CH_PAD : 8'h00;
      end
      crc_run = crc16_next(crc_run, b);
    end else if (p == len + 3) begin
      b = crc_run[15:8];
    end else begin
      b    = crc_run[7:0];
      last = 1'b1;
      ph   = ybs_pkg::PH_WAIT_ACK;
    end
    tx_pos = p + 11'd1;
    queue_tx(b, last);
  endtask

  task automatic take_payload(logic [7:0] b, logic last);
    logic [10:0] cap;
    cap = (kind == ybs_pkg::KIND_NAME) ? 11'(ybs_pkg::SHORT_BYTES) : 11'(ybs_pkg::BLOCK_BYTES);
    if (filled >= cap) begin
      abort_with(ybs_pkg::ST_OVERLONG);
      return;
    end
    frame_buf[filled[9:0]] = b;
    filled = filled + 11'd1;
    if (last) begin
      is_long = (kind == ybs_pkg::KIND_DATA) && (filled > ybs_pkg::SHORT_BYTES);
      if (kind == ybs_pkg::KIND_DATA && !strict_cfg) begin
        tries_left = (retries_cfg != 0) ? retries_cfg : 8'd1;
      end else begin
        tries_left = 8'd1;
      end
      start_frame();
    end
  endtask

  task automatic take_reply(logic [7:0] b);
    if (b == ybs_pkg::CH_ACK) begin
      if (kind == ybs_pkg::KIND_NAME) begin
        ph = ybs_pkg::PH_WAIT_C;
      end else if (kind == ybs_pkg::KIND_NULL) begin
        abort_with(ybs_pkg::ST_COMPLETE);
      end else begin
        blk_num = blk_num + 8'd1;
        start_fill(ybs_pkg::KIND_DATA);
        queue_status(ybs_pkg::ST_ACCEPTED);
      end
    end else if (b == ybs_pkg::CH_CAN && !strict_cfg) begin
      abort_with(ybs_pkg::ST_CANCELLED);
    end else if (tries_left > 1) begin
      tries_left = tries_left - 8'd1;
      start_frame();
    end else begin
      abort_with(ybs_pkg::ST_RETRIES);
    end
  endtask

  task automatic take_close_reply(logic [7:0] b);
    if (close_step == 0) begin
      if (!strict_cfg) begin
        abort_with(b == ybs_pkg::CH_ACK ? ybs_pkg::ST_COMPLETE : ybs_pkg::ST_RETRIES);
      end else if (b != ybs_pkg::CH_NAK) begin
        abort_with(ybs_pkg::ST_RETRIES);
      end else begin
        close_step = 3'd1;
        ph = ybs_pkg::PH_CLOSE_TX;
      end
    end else if (close_step == 1) begin
      if (b != ybs_pkg::CH_ACK) begin
        abort_with(ybs_pkg::ST_RETRIES);
      end else begin
        close_step = 3'd2;
      end
    end else if (b != ybs_pkg::CH_C) begin
      abort_with(ybs_pkg::ST_RETRIES);
    end else begin
      kind       = ybs_pkg::KIND_NULL;
      filled     = '0;
      is_long    = 1'b0;
      blk_num    = 8'd0;
      tries_left = 8'd1;
      start_frame();
    end
  endtask

  task automatic predict(ybs_pkg::in_beat_t x);
    logic [2:0] op;
    op = x.opcode;
    if (op == ybs_pkg::OP_START) begin
      hs_left    = (tries_cfg != 0) ? tries_cfg : 8'd1;
      blk_num    = 8'd0;
      close_step = 3'd0;
      ph         = ybs_pkg::PH_HANDSHAKE;
      return;
    end
    case (ph)
      ybs_pkg::PH_HANDSHAKE: begin
        if (op == ybs_pkg::OP_RX && x.data_byte == ybs_pkg::CH_C) begin
          blk_num = 8'd0;
          start_fill(ybs_pkg::KIND_NAME);
          queue_status(ybs_pkg::ST_READY);
        end else if (op == ybs_pkg::OP_RX || op == ybs_pkg::OP_TIMEOUT) begin
          if (hs_left > 1) begin
            hs_left = hs_left - 8'd1;
          end else begin
            abort_with(ybs_pkg::ST_HS_FAIL);
          end
        end
      end
      ybs_pkg::PH_FILL: begin
        if (op == ybs_pkg::OP_PAYLOAD) begin
          take_payload(x.data_byte, x.last_in_block);
        end else if (op == ybs_pkg::OP_EOF && kind == ybs_pkg::KIND_DATA && filled == 0) begin
          close_step = 3'd0;
          ph = ybs_pkg::PH_CLOSE_TX;
        end
      end
      ybs_pkg::PH_SEND: begin
        if (op == ybs_pkg::OP_PULL) next_frame_byte();
      end
      ybs_pkg::PH_WAIT_ACK: begin
        if (op == ybs_pkg::OP_RX) begin
          take_reply(x.data_byte);
        end else if (op == ybs_pkg::OP_TIMEOUT) begin
          abort_with(ybs_pkg::ST_NO_RESP);
        end
      end
      ybs_pkg::PH_WAIT_C: begin
        if (op == ybs_pkg::OP_RX) begin
          if (x.data_byte != ybs_pkg::CH_C) begin
            abort_with(ybs_pkg::ST_HS_FAIL);
          end else begin
            blk_num = 8'd1;
            start_fill(ybs_pkg::KIND_DATA);
            queue_status(ybs_pkg::ST_READY);
          end
        end else if (op == ybs_pkg::OP_TIMEOUT) begin
          abort_with(ybs_pkg::ST_NO_RESP);
        end
      end
      ybs_pkg::PH_CLOSE_TX: begin
        if (op == ybs_pkg::OP_PULL) begin
          ph = ybs_pkg::PH_CLOSE_RX;
          queue_tx(ybs_pkg::CH_EOT, 1'b1);
        end
      end
      ybs_pkg::PH_CLOSE_RX: begin
        if (op == ybs_pkg::OP_RX) begin
          take_close_reply(x.data_byte);
        end else if (op == ybs_pkg::OP_TIMEOUT) begin
          abort_with(ybs_pkg::ST_NO_RESP);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    ybs_pkg::out_beat_t want;
    if (rst) begin
      retries_cfg <= 8'd10;
      tries_cfg   <= 8'd10;
      strict_cfg  <= 1'b0;
      filled = '0; tx_pos = '0; blk_num = '0; is_long = 1'b0; crc_run = '0;
      tries_left = '0; hs_left = '0; ph = ybs_pkg::PH_IDLE; close_step = '0;
      kind = ybs_pkg::KIND_DATA;
      expected_beats.delete();
      errors <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ybs_pkg::REG_RETRY_LIMIT:     retries_cfg <= cfg_data;
          ybs_pkg::REG_HANDSHAKE_TRIES: tries_cfg   <= cfg_data;
          ybs_pkg::REG_ORIGINAL_MODE:   strict_cfg  <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          if (errors < 10) $display("unexpected output beat %p", out_data);
          errors <= errors + 1;
        end else begin
          want = expected_beats.pop_front();
          if (out_data.result_kind !== want.result_kind || out_data.tx_byte !== want.tx_byte ||
              out_data.last_of_packet !== want.last_of_packet ||
              out_data.status !== want.status) begin
            if (errors < 10) $display("mismatch: expected %p, got %p", want, out_data);
            errors <= errors + 1;
          end
        end
      end
      if (in_valid && !in_stall) predict(in_data);
    end
  end
endmodule

// File: tb/tb.sv
// Top of the testbench: clock, reset, stimulus sessions, output stall and the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid, in_stall, out_valid, out_stall, cfg_we;
  ybs_pkg::in_beat_t  in_data;
  ybs_pkg::out_beat_t out_data;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  int         errors, pending, cycles, beats_sent, stall_left;
  bit         in_burst, out_burst, strict_mode;

  always #5 clk = ~clk;

  ymodem_block_sender dut (
    .clk, .rst, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .cfg_we, .cfg_index, .cfg_data
  );

  ybs_checker scoreboard (
    .clk, .rst, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .cfg_we, .cfg_index, .cfg_data,
    .errors, .pending
  );

  function automatic int gap_len(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= 1'b0;
      stall_left <= gap_len(out_burst);
    end
  end

  // Called just after a rising edge; the previous beat's valid is lowered only on a gap.
  task automatic send_beat(logic [2:0] op, logic [7:0] b, logic last);
    int  g;
    bit  ok;
    g = gap_len(in_burst);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ybs_pkg::in_beat_t'{op, b, last};
    do begin
      @(negedge clk);
      ok = !in_stall;
      @(posedge clk);
    end while (!ok);
    beats_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(logic [7:0] retries, logic [7:0] tries, logic strict);
    drain();
    cfg_we <= 1'b1; cfg_index <= ybs_pkg::REG_RETRY_LIMIT; cfg_data <= retries;
    @(posedge clk);
    cfg_index <= ybs_pkg::REG_HANDSHAKE_TRIES; cfg_data <= tries;
    @(posedge clk);
    cfg_index <= ybs_pkg::REG_ORIGINAL_MODE; cfg_data <= {7'd0, strict};
    @(posedge clk);
    cfg_we <= 1'b0;
    strict_mode = strict;
  endtask

  task automatic noise();
    if ($urandom_range(0, 99) < 6) begin
      send_beat(3'($urandom_range(1, 7)), 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic fill_block(int n);
    for (int i = 0; i < n; i++) send_beat(ybs_pkg::OP_PAYLOAD, 8'($urandom), i == n - 1);
  endtask

  task automatic pull_frame(int n);
    repeat (n) send_beat(ybs_pkg::OP_PULL, 8'($urandom), 1'($urandom));
  endtask

  function automatic int data_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 40);
    if (r < 90) return $urandom_range(100, 140);
    if (r < 98) return $urandom_range(129, 300);
    return $urandom_range(1000, 1024);
  endfunction

  // One session: handshake, name block, data blocks, close. A forced header length hits the overlong name-block case.
  task automatic session(int hdr_len, int first_len, bit noisy);
    int n, nblocks, r, attempt;
    logic [7:0] reply;
    send_beat(ybs_pkg::OP_START, 8'($urandom), 1'($urandom));
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 1)) send_beat(ybs_pkg::OP_TIMEOUT, 8'($urandom), 1'($urandom));
      else send_beat(ybs_pkg::OP_RX, 8'($urandom_range(0, 66)), 1'($urandom));
    end
    send_beat(ybs_pkg::OP_RX, ybs_pkg::CH_C, 1'($urandom));
    fill_block(hdr_len);
    pull_frame(133);
    send_beat(ybs_pkg::OP_RX, ybs_pkg::CH_ACK, 1'($urandom));
    if (noisy) noise();
    send_beat(ybs_pkg::OP_RX, ybs_pkg::CH_C, 1'($urandom));
    nblocks = $urandom_range(1, 3);
    for (int k = 0; k < nblocks; k++) begin
      n = (k == 0 && first_len > 0) ? first_len : data_len();
      if (noisy) noise();
      fill_block(n);
      attempt = 0;
      do begin
        pull_frame(n > 128 ? 1029 : 133);
        if (noisy) noise();
        r = $urandom_range(0, 99);
        reply = ybs_pkg::CH_ACK;
        if (attempt < 3 && r >= 80) begin
          if (r < 88) reply = ybs_pkg::CH_NAK;
          else if (r < 92) reply = ybs_pkg::CH_CAN;
          else reply = 8'($urandom);
        end
        if (attempt < 3 && r >= 96) begin
          send_beat(ybs_pkg::OP_TIMEOUT, 8'($urandom), 1'($urandom));
        end else begin
          send_beat(ybs_pkg::OP_RX, reply, 1'($urandom));
        end
        attempt++;
      end while (reply != ybs_pkg::CH_ACK && attempt < 4);
    end
    send_beat(ybs_pkg::OP_EOF, 8'($urandom), 1'($urandom));
    send_beat(ybs_pkg::OP_PULL, 8'($urandom), 1'($urandom));
    if (strict_mode) begin
      send_beat(ybs_pkg::OP_RX, ybs_pkg::CH_NAK, 1'($urandom));
      send_beat(ybs_pkg::OP_PULL, 8'($urandom), 1'($urandom));
      send_beat(ybs_pkg::OP_RX, ybs_pkg::CH_ACK, 1'($urandom));
      send_beat(ybs_pkg::OP_RX, ybs_pkg::CH_C, 1'($urandom));
      pull_frame(133);
    end
    if (noisy) noise();
    send_beat(ybs_pkg::OP_RX, ybs_pkg::CH_ACK, 1'($urandom));
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= ybs_pkg::REG_RETRY_LIMIT;
    cfg_data  <= 8'd0;
    beats_sent = 0;
    in_burst  = 0;
    out_burst = 0;
    strict_mode = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings, overlong name block, handshake failure, strict close.
    session(5, 3, 0);
    session(129, 0, 0);
    write_regs(8'd1, 8'd1, 1'b0);
    send_beat(ybs_pkg::OP_START, 8'h00, 1'b0);
    send_beat(ybs_pkg::OP_RX, ybs_pkg::CH_NAK, 1'b1);
    write_regs(8'd255, 8'd255, 1'b1);
    session(1, 0, 0);
    write_regs(8'd3, 8'd2, 1'b0);
    session(2, 0, 0);
    drain();

    while (beats_sent < 2000) begin
      case ($urandom_range(0, 5))
        0: write_regs(8'd1, 8'd1, 1'($urandom));
        1: write_regs(8'd255, 8'd255, 1'($urandom));
        default: write_regs(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                            1'($urandom));
      endcase
      repeat ($urandom_range(1, 4)) begin
        in_burst  = ($urandom_range(0, 4) == 0);
        out_burst = ($urandom_range(0, 4) == 0);
        session($urandom_range(1, 20), 0, 1);
        if ($urandom_range(0, 3) == 0) drain();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
